>>> rtl/ofgv_pkg.sv
// Package for the optical flow ground velocity unit: types, constants, program table.
package ofgv_pkg;

  localparam int unsigned CfgAddrWidth = 4;
  localparam int unsigned CfgDataWidth = 32;

  localparam logic [15:0] PPR_RESET = 16'd41728;
  localparam logic [23:0] MF_RESET  = 24'd103180;
  localparam logic [7:0]  QTH_RESET = 8'd10;

  // 45 degrees in Q2.13 radians
  localparam logic signed [15:0] TILT_LIMIT = 16'sd6433;

  // raw count times 32, shifted up 16, gives Q.21
  localparam logic signed [17:0] COUNT_SCALE = 18'sd32;

  // half an LSB for the Q.14 and Q.24 round-half-up steps
  localparam logic signed [63:0] RND14 = 64'sh0000_0000_0000_2000;
  localparam logic signed [63:0] RND24 = 64'sh0000_0000_0080_0000;

  localparam logic [3:0] LAST_ISSUE = 4'd13;
  localparam logic [3:0] DRAIN_STEP = 4'd14;

  typedef enum logic [1:0] {
    REG_PPR = 2'd0,
    REG_MF  = 2'd1,
    REG_QTH = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_cosine;
    logic signed [15:0] yaw_sine;
    logic signed [15:0] height;
    logic [7:0]         quality;
    logic               moved;
    logic signed [7:0]  delta_x;
    logic signed [7:0]  delta_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] velocity_lon;
    logic signed [31:0] velocity_lat;
    logic               accepted;
    logic signed [15:0] sum_x;
    logic signed [15:0] sum_y;
  } out_item_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_CALC,
    SEQ_DONE
  } seq_state_t;

  typedef enum logic [2:0] {
    A_DROLL,
    A_DPITCH,
    A_DX,
    A_DY,
    A_NCX,
    A_NCY,
    A_XCM,
    A_YCM
  } a_sel_t;

  typedef enum logic [2:0] {
    B_PPR,
    B_SCALE,
    B_HSUM,
    B_MF_LO,
    B_MF_HI,
    B_SIN,
    B_COS
  } b_sel_t;

  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_ACC,
    BASE_RND14,
    BASE_RND24
  } base_t;

  typedef enum logic [3:0] {
    DEST_NONE,
    DEST_NCX,
    DEST_NCY,
    DEST_XCM_H,
    DEST_YCM_H,
    DEST_XCM_M,
    DEST_YCM_M,
    DEST_LON,
    DEST_LAT
  } dest_t;

  typedef struct packed {
    logic   valid;
    a_sel_t a_sel;
    b_sel_t b_sel;
    logic   shift_hi;
    logic   negate;
    base_t  base;
    dest_t  dest;
  } mac_op_t;

  typedef struct packed {
    logic idle;
    logic load_out;
  } seq_status_t;

  localparam mac_op_t OP_NOP = '{
    valid: 1'b0, a_sel: A_DROLL, b_sel: B_PPR, shift_hi: 1'b0,
    negate: 1'b0, base: BASE_ZERO, dest: DEST_NONE
  };

  function automatic mac_op_t mk_op(input a_sel_t a, input b_sel_t b, input logic hi,
                                    input logic neg, input base_t base, input dest_t dest);
    mac_op_t op;
    op.valid    = 1'b1;
    op.a_sel    = a;
    op.b_sel    = b;
    op.shift_hi = hi;
    op.negate   = neg;
    op.base     = base;
    op.dest     = dest;
    return op;
  endfunction

  // one multiply-accumulate issue per step
  function automatic mac_op_t prog(input logic [3:0] step);
    mac_op_t op;
    op = OP_NOP;
    unique case (step)
      4'd0:    op = mk_op(A_DROLL,  B_PPR,   1'b0, 1'b0, BASE_ZERO,  DEST_NONE);
      4'd1:    op = mk_op(A_DX,     B_SCALE, 1'b1, 1'b1, BASE_ACC,   DEST_NCX);
      4'd2:    op = mk_op(A_DPITCH, B_PPR,   1'b0, 1'b1, BASE_ZERO,  DEST_NONE);
      4'd3:    op = mk_op(A_DY,     B_SCALE, 1'b1, 1'b1, BASE_ACC,   DEST_NCY);
      4'd4:    op = mk_op(A_NCX,    B_HSUM,  1'b0, 1'b0, BASE_RND14, DEST_XCM_H);
      4'd5:    op = mk_op(A_NCY,    B_HSUM,  1'b0, 1'b0, BASE_RND14, DEST_YCM_H);
      4'd6:    op = mk_op(A_XCM,    B_MF_LO, 1'b0, 1'b0, BASE_RND24, DEST_NONE);
      4'd7:    op = mk_op(A_XCM,    B_MF_HI, 1'b1, 1'b0, BASE_ACC,   DEST_XCM_M);
      4'd8:    op = mk_op(A_YCM,    B_MF_LO, 1'b0, 1'b0, BASE_RND24, DEST_NONE);
      4'd9:    op = mk_op(A_YCM,    B_MF_HI, 1'b1, 1'b0, BASE_ACC,   DEST_YCM_M);
      4'd10:   op = mk_op(A_XCM,    B_SIN,   1'b0, 1'b0, BASE_RND14, DEST_NONE);
      4'd11:   op = mk_op(A_YCM,    B_COS,   1'b0, 1'b0, BASE_ACC,   DEST_LON);
      4'd12:   op = mk_op(A_YCM,    B_SIN,   1'b0, 1'b0, BASE_RND14, DEST_NONE);
      4'd13:   op = mk_op(A_XCM,    B_COS,   1'b0, 1'b1, BASE_ACC,   DEST_LAT);
      default: op = OP_NOP;
    endcase
    return op;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/ofgv_mac.sv
// Shared two-stage multiply-accumulate unit: product register, then accumulator.
module ofgv_mac (
  input  logic                  clk,
  input  logic                  rst,
  input  ofgv_pkg::mac_op_t     op,
  input  logic signed [39:0]    a,
  input  logic signed [17:0]    b,
  output ofgv_pkg::mac_op_t     done_op,
  output logic signed [63:0]    res
);

  ofgv_pkg::mac_op_t  op1;
  logic signed [57:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] term;
  logic signed [63:0] addend;
  logic signed [63:0] base_val;

  always_ff @(posedge clk) begin
    prod <= a * b;
    if (rst) begin
      op1 <= ofgv_pkg::OP_NOP;
    end else begin
      op1 <= op;
    end
  end

  always_comb begin
    term = {{6{prod[57]}}, prod};
    if (op1.shift_hi) begin
      term = {term[47:0], 16'b0};
    end
    addend = op1.negate ? -term : term;
    case (op1.base)
      ofgv_pkg::BASE_ACC:   base_val = acc;
      ofgv_pkg::BASE_RND14: base_val = ofgv_pkg::RND14;
      ofgv_pkg::BASE_RND24: base_val = ofgv_pkg::RND24;
      default:              base_val = '0;
    endcase
    res = base_val + addend;
  end

  always_ff @(posedge clk) begin
    if (op1.valid) begin
      acc <= res;
    end
  end

  assign done_op = op1;

endmodule

>>> rtl/ofgv_seq.sv
// Sequencer: steps the multiply-accumulate program and hands off the result.
module ofgv_seq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  skip,
  input  logic                  out_free,
  output ofgv_pkg::mac_op_t     op,
  output ofgv_pkg::seq_status_t status
);

  ofgv_pkg::seq_state_t state;
  ofgv_pkg::seq_state_t state_next;
  logic [3:0]           step;
  logic [3:0]           step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ofgv_pkg::SEQ_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next      = state;
    step_next       = step;
    op              = ofgv_pkg::OP_NOP;
    status.idle     = 1'b0;
    status.load_out = 1'b0;
    unique case (state)
      ofgv_pkg::SEQ_IDLE: begin
        status.idle = 1'b1;
        step_next   = '0;
        if (start) begin
          state_next = ofgv_pkg::SEQ_CALC;
        end else if (skip) begin
          state_next = ofgv_pkg::SEQ_DONE;
        end
      end
      ofgv_pkg::SEQ_CALC: begin
        if (step <= ofgv_pkg::LAST_ISSUE) begin
          op = ofgv_pkg::prog(step);
        end
        step_next = step + 4'd1;
        if (step == ofgv_pkg::DRAIN_STEP) begin
          state_next = ofgv_pkg::SEQ_DONE;
        end
      end
      ofgv_pkg::SEQ_DONE: begin
        if (out_free) begin
          status.load_out = 1'b1;
          state_next      = ofgv_pkg::SEQ_IDLE;
        end
      end
      default: state_next = ofgv_pkg::SEQ_IDLE;
    endcase
  end

endmodule

>>> rtl/optical_flow_ground_velocity_unit.sv
// Top level of the optical flow ground velocity unit: ports, registers, operand select.
//
//  channel  | direction | handshake               | payload
//  in       | input     | in_valid / in_stall     | in_data  (ofgv_pkg::in_item_t)
//  out      | output    | out_valid / out_stall   | out_data (ofgv_pkg::out_item_t)
//  config   | input     | psel/penable/pwrite     | paddr, pwdata, prdata, pready
//
// A gated-off sample skips the calculation and goes straight to the done state.
// An accepted sample runs 14 issues through one 40x18 multiply-accumulate unit
// (two stages); after a drain step the done state loads the result and returns to
// idle to take the next sample. The output register frees the input side while a
// result waits; a stalled output only holds the block when the next result is due.
// Reset clears configuration to defaults and all kept state to zero.
module optical_flow_ground_velocity_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  ofgv_pkg::in_item_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output ofgv_pkg::out_item_t                   out_data,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ofgv_pkg::CfgAddrWidth-1:0]     paddr,
  input  logic [ofgv_pkg::CfgDataWidth-1:0]     pwdata,
  output logic [ofgv_pkg::CfgDataWidth-1:0]     prdata,
  output logic                                  pready
);

  logic [15:0] ppr;
  logic [23:0] mf;
  logic [7:0]  qth;

  logic signed [15:0] prev_roll;
  logic signed [15:0] prev_pitch;
  logic signed [15:0] prev_height;
  logic signed [15:0] total_x;
  logic signed [15:0] total_y;
  logic signed [31:0] held_lon;
  logic signed [31:0] held_lat;
  logic               acc_flag;

  logic signed [16:0] droll;
  logic signed [16:0] dpitch;
  logic signed [7:0]  dx;
  logic signed [7:0]  dy;
  logic signed [17:0] hsum;
  logic signed [15:0] ysin;
  logic signed [15:0] ycos;
  logic signed [33:0] ncx;
  logic signed [33:0] ncy;
  logic signed [37:0] xcm;
  logic signed [37:0] ycm;

  logic               accept;
  logic               cfg_write;
  logic               gate;
  logic signed [7:0]  dx_in;
  logic signed [7:0]  dy_in;
  logic signed [15:0] h_clamp;
  logic               out_free;

  ofgv_pkg::mac_op_t     op;
  ofgv_pkg::mac_op_t     done_op;
  ofgv_pkg::seq_status_t status;
  logic signed [39:0]    mac_a;
  logic signed [17:0]    mac_b;
  logic signed [63:0]    res;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = !status.idle;
  assign out_free  = !out_valid || !out_stall;

  assign dx_in   = in_data.moved ? in_data.delta_x : 8'sd0;
  assign dy_in   = in_data.moved ? in_data.delta_y : 8'sd0;
  assign h_clamp = in_data.height[15] ? 16'sd0 : in_data.height;
  assign gate    = (in_data.quality >= qth)
                && (in_data.roll_angle <= ofgv_pkg::TILT_LIMIT)
                && (in_data.roll_angle >= -ofgv_pkg::TILT_LIMIT)
                && (in_data.pitch_angle <= ofgv_pkg::TILT_LIMIT)
                && (in_data.pitch_angle >= -ofgv_pkg::TILT_LIMIT);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      ppr <= ofgv_pkg::PPR_RESET;
      mf  <= ofgv_pkg::MF_RESET;
      qth <= ofgv_pkg::QTH_RESET;
    end else if (cfg_write) begin
      unique case (ofgv_pkg::cfg_reg_t'(paddr[3:2]))
        ofgv_pkg::REG_PPR: ppr <= pwdata[15:0];
        ofgv_pkg::REG_MF:  mf  <= pwdata[23:0];
        ofgv_pkg::REG_QTH: qth <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ofgv_pkg::cfg_reg_t'(paddr[3:2]))
      ofgv_pkg::REG_PPR: prdata = {16'b0, ppr};
      ofgv_pkg::REG_MF:  prdata = {8'b0, mf};
      ofgv_pkg::REG_QTH: prdata = {24'b0, qth};
      default:           prdata = '0;
    endcase
  end

  // sample capture and kept state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_roll   <= '0;
      prev_pitch  <= '0;
      prev_height <= '0;
      total_x     <= '0;
      total_y     <= '0;
      acc_flag    <= 1'b0;
    end else if (accept) begin
      prev_roll   <= in_data.roll_angle;
      prev_pitch  <= in_data.pitch_angle;
      prev_height <= gate ? h_clamp : in_data.height;
      total_x     <= total_x + {{8{dx_in[7]}}, dx_in};
      total_y     <= total_y + {{8{dy_in[7]}}, dy_in};
      acc_flag    <= gate;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      droll  <= {in_data.roll_angle[15], in_data.roll_angle} - {prev_roll[15], prev_roll};
      dpitch <= {in_data.pitch_angle[15], in_data.pitch_angle}
              - {prev_pitch[15], prev_pitch};
      dx     <= dx_in;
      dy     <= dy_in;
      hsum   <= {2'b0, h_clamp} + {{2{prev_height[15]}}, prev_height};
      ysin   <= in_data.yaw_sine;
      ycos   <= in_data.yaw_cosine;
    end
  end

  // operand select
  always_comb begin
    case (op.a_sel)
      ofgv_pkg::A_DROLL:  mac_a = {{23{droll[16]}}, droll};
      ofgv_pkg::A_DPITCH: mac_a = {{23{dpitch[16]}}, dpitch};
      ofgv_pkg::A_DX:     mac_a = {{32{dx[7]}}, dx};
      ofgv_pkg::A_DY:     mac_a = {{32{dy[7]}}, dy};
      ofgv_pkg::A_NCX:    mac_a = {{6{ncx[33]}}, ncx};
      ofgv_pkg::A_NCY:    mac_a = {{6{ncy[33]}}, ncy};
      ofgv_pkg::A_XCM:    mac_a = {{2{xcm[37]}}, xcm};
      ofgv_pkg::A_YCM:    mac_a = {{2{ycm[37]}}, ycm};
      default:            mac_a = '0;
    endcase
    case (op.b_sel)
      ofgv_pkg::B_PPR:   mac_b = {2'b0, ppr};
      ofgv_pkg::B_SCALE: mac_b = ofgv_pkg::COUNT_SCALE;
      ofgv_pkg::B_HSUM:  mac_b = hsum;
      ofgv_pkg::B_MF_LO: mac_b = {2'b0, mf[15:0]};
      ofgv_pkg::B_MF_HI: mac_b = {10'b0, mf[23:16]};
      ofgv_pkg::B_SIN:   mac_b = {{2{ysin[15]}}, ysin};
      ofgv_pkg::B_COS:   mac_b = {{2{ycos[15]}}, ycos};
      default:           mac_b = '0;
    endcase
  end

  ofgv_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .a       (mac_a),
    .b       (mac_b),
    .done_op (done_op),
    .res     (res)
  );

  ofgv_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept && gate),
    .skip     (accept && !gate),
    .out_free (out_free),
    .op       (op),
    .status   (status)
  );

  // intermediate results
  always_ff @(posedge clk) begin
    if (done_op.valid) begin
      case (done_op.dest)
        ofgv_pkg::DEST_NCX:   ncx <= res[33:0];
        ofgv_pkg::DEST_NCY:   ncy <= res[33:0];
        ofgv_pkg::DEST_XCM_H: xcm <= res[51:14];
        ofgv_pkg::DEST_YCM_H: ycm <= res[51:14];
        ofgv_pkg::DEST_XCM_M: xcm <= res[61:24];
        ofgv_pkg::DEST_YCM_M: ycm <= res[61:24];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_lon <= '0;
      held_lat <= '0;
    end else if (done_op.valid) begin
      if (done_op.dest == ofgv_pkg::DEST_LON) begin
        held_lon <= ofgv_pkg::sat32(res[63:14]);
      end
      if (done_op.dest == ofgv_pkg::DEST_LAT) begin
        held_lat <= ofgv_pkg::sat32(res[63:14]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (status.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (status.load_out) begin
      out_data.velocity_lon <= held_lon;
      out_data.velocity_lat <= held_lat;
      out_data.accepted     <= acc_flag;
      out_data.sum_x        <= total_x;
      out_data.sum_y        <= total_y;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input side open right after a transfer");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    status.load_out |-> out_free)
    else $error("result loaded over a stalled output");

  a_mac_only_busy: assert property (@(posedge clk) disable iff (rst)
    done_op.valid |-> !status.idle && !$past(status.idle))
    else $error("multiply-accumulate active while idle");
`endif

endmodule

>>> verif/ofgv_checker.sv
// Checker for the optical flow ground velocity unit: tracks register writes, predicts and compares results.
module ofgv_checker
  import ofgv_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  in_item_t                in_data,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  out_item_t               out_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  input  logic                    pready,
  output int                      mismatches,
  output int                      outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint TiltQ13 = 6433;

  logic [15:0]        ppr;
  logic [23:0]        mf;
  logic [7:0]         qth;
  logic signed [15:0] last_roll;
  logic signed [15:0] last_pitch;
  logic signed [15:0] last_height;
  logic [15:0]        total_x;
  logic [15:0]        total_y;
  logic signed [31:0] hold_lon;
  logic signed [31:0] hold_lat;

  out_item_t velocity_q[$];

  function automatic longint round_down(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [31:0] clip32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic out_item_t ground_velocity_step(input in_item_t s);
    out_item_t r;
    longint roll, pitch, h, dx, dy, k, mfl, chg_x, chg_y, hsum, xcm, ycm, yc, ys;
    logic gate;
    roll  = longint'(s.roll_angle);
    pitch = longint'(s.pitch_angle);
    h     = longint'(s.height);
    yc    = longint'(s.yaw_cosine);
    ys    = longint'(s.yaw_sine);
    dx    = s.moved ? longint'(s.delta_x) : 0;
    dy    = s.moved ? longint'(s.delta_y) : 0;
    total_x = total_x + 16'(dx);
    total_y = total_y + 16'(dy);
    gate = (s.quality >= qth) && roll <= TiltQ13 && roll >= -TiltQ13 &&
           pitch <= TiltQ13 && pitch >= -TiltQ13;
    if (gate) begin
      k     = longint'(ppr);
      mfl   = longint'(mf);
      chg_x = dx * (64'sd1 <<< 21) - (roll - longint'(last_roll)) * k;
      chg_y = dy * (64'sd1 <<< 21) + (pitch - longint'(last_pitch)) * k;
      if (h < 0) h = 0;
      hsum = h + longint'(last_height);
      xcm  = round_down(-chg_x * hsum, 14);
      ycm  = round_down(-chg_y * hsum, 14);
      xcm  = round_down(xcm * mfl, 24);
      ycm  = round_down(ycm * mfl, 24);
      hold_lon = clip32(round_down(xcm * ys + ycm * yc, 14));
      hold_lat = clip32(round_down(ycm * ys - xcm * yc, 14));
    end
    last_height = 16'(h);
    last_roll   = s.roll_angle;
    last_pitch  = s.pitch_angle;
    r.velocity_lon = hold_lon;
    r.velocity_lat = hold_lat;
    r.accepted     = gate;
    r.sum_x        = total_x;
    r.sum_y        = total_y;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      ppr         = PPR_RESET;
      mf          = MF_RESET;
      qth         = QTH_RESET;
      last_roll   = '0;
      last_pitch  = '0;
      last_height = '0;
      total_x     = '0;
      total_y     = '0;
      hold_lon    = '0;
      hold_lat    = '0;
      velocity_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_t'(paddr[3:2]))
          REG_PPR: ppr = pwdata[15:0];
          REG_MF:  mf  = pwdata[23:0];
          REG_QTH: qth = pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) velocity_q.push_back(ground_velocity_step(in_data));
      if (out_valid && !out_stall) begin
        if (velocity_q.size() == 0) begin
          $display("%0t: unexpected transfer, actual lon %0d lat %0d", $time,
                   out_data.velocity_lon, out_data.velocity_lat);
          mismatches++;
        end else begin
          want = velocity_q.pop_front();
          check_field("velocity_lon", want.velocity_lon, out_data.velocity_lon);
          check_field("velocity_lat", want.velocity_lat, out_data.velocity_lat);
          check_field("accepted", want.accepted, out_data.accepted);
          check_field("sum_x", want.sum_x, out_data.sum_x);
          check_field("sum_y", want.sum_y, out_data.sum_y);
        end
      end
    end
    outstanding = velocity_q.size();
  end

endmodule

>>> verif/tb_optical_flow_ground_velocity_unit.sv
// Testbench top for the optical flow ground velocity unit: clock, reset, stimulus and verdict.
module tb_optical_flow_ground_velocity_unit;
  import ofgv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  in_item_t                in_data;
  logic                    out_valid;
  logic                    out_stall;
  out_item_t               out_data;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;
  int                      mismatches;
  int                      pending;

  int         snd_idle_pct = 0;
  int         rcv_stall_pct = 0;
  bit         hold_wanted = 1'b0;
  bit         hold_done = 1'b0;
  logic [7:0] cur_qth = QTH_RESET;

  optical_flow_ground_velocity_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ofgv_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .mismatches (mismatches),
    .outstanding(pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // output side: random stalls, plus one long hold-off to back the block up
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_done) begin
        out_stall = 1'b1;
        repeat (400) @(negedge clk);
        hold_done = 1'b1;
      end
      out_stall = ($urandom_range(0, 99) < rcv_stall_pct);
    end
  end

  function automatic in_item_t mk_sample(input int roll, input int pitch, input int ycos,
                                         input int ysin, input int h, input int q,
                                         input bit mv, input int dx, input int dy);
    in_item_t s;
    s.roll_angle  = 16'(roll);
    s.pitch_angle = 16'(pitch);
    s.yaw_cosine  = 16'(ycos);
    s.yaw_sine    = 16'(ysin);
    s.height      = 16'(h);
    s.quality     = 8'(q);
    s.moved       = mv;
    s.delta_x     = 8'(dx);
    s.delta_y     = 8'(dy);
    return s;
  endfunction

  // mostly gated-in samples; counts drift so the totals wrap
  function automatic in_item_t random_sample();
    in_item_t s;
    if ($urandom_range(0, 9) < 7) s.roll_angle = 16'(int'($urandom_range(0, 12866)) - 6433);
    else s.roll_angle = 16'($urandom);
    if ($urandom_range(0, 9) < 7) s.pitch_angle = 16'(int'($urandom_range(0, 12866)) - 6433);
    else s.pitch_angle = 16'($urandom);
    s.yaw_cosine = 16'(int'($urandom_range(0, 32768)) - 16384);
    s.yaw_sine   = 16'(int'($urandom_range(0, 32768)) - 16384);
    case ($urandom_range(0, 19))
      0, 1, 2:  s.height = 16'(-int'($urandom_range(1, 32768)));
      3, 4:     s.height = 16'($urandom);
      default:  s.height = 16'($urandom_range(0, 4000));
    endcase
    if ($urandom_range(0, 4) != 0) s.quality = 8'($urandom_range(cur_qth, 255));
    else s.quality = 8'($urandom);
    s.moved = ($urandom_range(0, 6) != 0);
    if ($urandom_range(0, 4) < 2) s.delta_x = 8'($urandom_range(96, 127));
    else s.delta_x = 8'($urandom);
    if ($urandom_range(0, 4) < 2) s.delta_y = 8'(int'($urandom_range(0, 32)) - 128);
    else s.delta_y = 8'($urandom);
    return s;
  endfunction

  task automatic send_sample(input in_item_t s);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic reconfigure(input logic [15:0] k, input logic [23:0] m, input logic [7:0] q);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (20) @(negedge clk);
    write_reg(REG_PPR, {16'b0, k});
    write_reg(REG_MF, {8'b0, m});
    write_reg(REG_QTH, {24'b0, q});
    cur_qth = q;
  endtask

  task automatic run_random(input int snd, input int rcv, input int count);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
    repeat (count) send_sample(random_sample());
  endtask

  initial begin
    in_item_t directed[$];
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // threshold edges, tilt limits, motion bit off, height clamp and negative mean
    directed.push_back(mk_sample(0, 0, 16384, 0, 0, 10, 1, 0, 0));
    directed.push_back(mk_sample(100, -100, 16384, 0, 500, 9, 1, 5, 5));
    directed.push_back(mk_sample(6433, -6433, 16384, 0, 1000, 255, 1, 127, -128));
    directed.push_back(mk_sample(-6433, 6433, 0, 16384, 1000, 200, 1, -128, 127));
    directed.push_back(mk_sample(6434, 0, 16384, 0, 1000, 200, 1, 3, 3));
    directed.push_back(mk_sample(-6434, 0, 16384, 0, 1000, 200, 1, 3, 3));
    directed.push_back(mk_sample(0, 6434, 16384, 0, 1000, 200, 1, 3, 3));
    directed.push_back(mk_sample(0, -6434, 16384, 0, 1000, 200, 1, 3, 3));
    directed.push_back(mk_sample(-32768, 0, 16384, 0, 1000, 200, 1, 3, 3));
    directed.push_back(mk_sample(0, -32768, 16384, 0, 1000, 200, 1, 3, 3));
    directed.push_back(mk_sample(32767, 32767, 16384, 0, 1000, 200, 1, 3, 3));
    directed.push_back(mk_sample(0, 0, -16384, 16384, 800, 50, 0, -128, 127));
    directed.push_back(mk_sample(200, -300, 16384, -16384, -32768, 50, 1, 60, -60));
    directed.push_back(mk_sample(0, 0, 16384, 0, -500, 0, 1, 10, 10));
    directed.push_back(mk_sample(100, 100, 11585, 11585, 200, 80, 1, -20, 30));
    directed.push_back(mk_sample(6433, 6433, -16384, -16384, 32767, 255, 1, 127, 127));
    directed.push_back(mk_sample(-6433, -6433, 0, -16384, 32767, 255, 1, -128, -128));
    directed.push_back(mk_sample(0, 0, 16384, 16384, 32767, 255, 1, 127, 127));
    directed.push_back(mk_sample(3000, -3000, -11585, 11585, 1500, 0, 1, 0, 0));
    foreach (directed[i]) send_sample(directed[i]);

    run_random(0, 0, 370);
    reconfigure(16'hFFFF, 24'hFF_FFFF, 8'd0);
    run_random(47, 0, 380);
    reconfigure(16'd0, 24'd0, 8'hFF);
    run_random(0, 47, 380);
    reconfigure(16'($urandom), 24'($urandom), 8'($urandom));
    run_random(13, 13, 380);
    reconfigure(PPR_RESET, MF_RESET, QTH_RESET);
    hold_wanted = 1'b1;
    run_random(0, 0, 380);

    in_valid = 1'b0;
    wait (pending == 0);
    repeat (40) @(negedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> optical_flow_ground_velocity_unit.f
rtl/ofgv_pkg.sv
rtl/ofgv_mac.sv
rtl/ofgv_seq.sv
rtl/optical_flow_ground_velocity_unit.sv
verif/ofgv_checker.sv
verif/tb_optical_flow_ground_velocity_unit.sv
